// File: rtl/fpa_pkg.sv
`timescale 1ns / 1ps

package fpa_pkg;

   // Operation codes
   typedef enum logic [3:0] {
      MODE_ADD     = 4'd0,
      MODE_SUB     = 4'd1,
      MODE_MUL     = 4'd2,
      MODE_DIV     = 4'd3,
      MODE_GT      = 4'd4,
      MODE_LT      = 4'd5,
      MODE_GE      = 4'd6,
      MODE_LE      = 4'd7,
      MODE_EQ      = 4'd8,
      MODE_NE      = 4'd9,
      MODE_MIN     = 4'd10,
      MODE_MAX     = 4'd11,
      MODE_INC     = 4'd12,
      MODE_DEC     = 4'd13,
      MODE_TOINT   = 4'd14,
      MODE_FROMINT = 4'd15
   } mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_OVF = 2'd1,
      ST_DZ  = 2'd2
   } status_type;

   localparam int DATA_BITS = 32;

   // Per-item info that rides alongside the divider stages
   typedef struct packed {
      mode_type              mode;
      logic [DATA_BITS-1:0]  result;
      logic                  cmp;
      status_type            status;
      logic                  neg;
   } side_type;

endpackage

// File: rtl/fpa_if.sv
`timescale 1ns / 1ps

interface fpa_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  mode;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] result_raw;
   logic        compare_true;
   logic [1:0]  status;

   modport source (output valid, result_raw, compare_true, status, input ready);
   modport sink   (input valid, result_raw, compare_true, status, output ready);
endinterface

// File: rtl/fixed_point_alu.sv
`timescale 1ns / 1ps

// Signed fixed-point ALU, FRAC_BITS fraction bits in a WORD_BITS word (Q24.8
// by default). One transfer in gives one transfer out, in order. Every
// operation runs through the same pipeline of 3 + (WORD_BITS + FRAC_BITS + 1)
// + 1 stages, set by the divider, which resolves one quotient bit per stage.
// A new item is taken every cycle; the whole pipeline holds when the output
// register is full and not taken. Multiply and divide round half away from
// zero; overflow saturates with status 1, divide by zero saturates by the
// dividend's sign with status 2.
module fixed_point_alu #(
   parameter int FRAC_BITS = 8,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   fpa_req_if.sink     req_chan,
   fpa_rsp_if.source   rsp_chan
);

   localparam int NW = WORD_BITS + FRAC_BITS + 1;
   localparam int DW = WORD_BITS + 1;
   localparam logic [NW-1:0] QLIM_POS = NW'((64'd1 << (WORD_BITS - 1)) - 64'd1);
   localparam logic [NW-1:0] QLIM_NEG = NW'(64'd1 << (WORD_BITS - 1));
   localparam logic [31:0] WMAX = 32'((64'd1 << (WORD_BITS - 1)) - 64'd1);
   localparam logic [31:0] WMIN = ~WMAX;

   logic               en;
   logic               f_valid, d_valid;
   fpa_pkg::side_type  f_side, d_side;
   logic [NW-1:0]      f_num, d_quot;
   logic [DW-1:0]      f_den;

   logic               rsp_valid_ff;
   logic [31:0]        result_ff, result_in;
   logic               cmp_ff;
   fpa_pkg::status_type status_ff, status_in;

   // whole pipeline advances when the output slot is free or being taken
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   fpa_front #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS),
      .NW        (NW),
      .DW        (DW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_mode   (req_chan.mode),
      .in_a      (req_chan.operand_a),
      .in_b      (req_chan.operand_b),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_num   (f_num),
      .out_den   (f_den)
   );

   fpa_divider #(
      .NW (NW),
      .DW (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_num    (f_num),
      .in_den    (f_den),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_quot  (d_quot)
   );

   // Final stage: clamp and sign the quotient for divides
   always_comb begin
      result_in = d_side.result;
      status_in = d_side.status;
      if (d_side.mode == fpa_pkg::MODE_DIV && d_side.status != fpa_pkg::ST_DZ) begin
         if (d_quot > (d_side.neg ? QLIM_NEG : QLIM_POS)) begin
            status_in = fpa_pkg::ST_OVF;
            result_in = d_side.neg ? WMIN : WMAX;
         end else begin
            result_in = d_side.neg ? 32'(-d_quot) : 32'(d_quot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
         cmp_ff    <= d_side.cmp;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_raw   = result_ff;
   assign rsp_chan.compare_true = cmp_ff;
   assign rsp_chan.status       = status_ff;

endmodule

// File: rtl/fpa_front.sv
`timescale 1ns / 1ps

// Three front stages: operand capture, simple ops plus multiply and divider
// operand setup, multiply rounding.
module fpa_front #(
   parameter int FRAC_BITS = 8,
   parameter int WORD_BITS = 32,
   parameter int NW        = WORD_BITS + FRAC_BITS + 1,
   parameter int DW        = WORD_BITS + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [3:0]           in_mode,
   input  logic signed [31:0]   in_a,
   input  logic signed [31:0]   in_b,
   output logic                 out_valid,
   output fpa_pkg::side_type    out_side,
   output logic [NW-1:0]        out_num,
   output logic [DW-1:0]        out_den
);

   localparam logic signed [33:0] WMAX34 = 34'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
   localparam logic signed [33:0] WMIN34 = -WMAX34 - 34'sd1;
   localparam logic signed [49:0] WMAX50 = 50'(WMAX34);
   localparam logic signed [49:0] WMIN50 = 50'(WMIN34);
   localparam logic [63:0] HALF = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
   localparam logic [63:0] LIM_POS = (64'd1 << (WORD_BITS - 1)) - 64'd1;
   localparam logic [63:0] LIM_NEG = 64'd1 << (WORD_BITS - 1);

   // Stage A: sign-extend the low word of each operand
   logic                 va_ff;
   fpa_pkg::mode_type    mode_a_ff;
   logic signed [31:0]   a_ff, b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_a_ff <= fpa_pkg::mode_type'(in_mode);
         a_ff      <= 32'($signed(in_a[WORD_BITS-1:0]));
         b_ff      <= 32'($signed(in_b[WORD_BITS-1:0]));
      end
   end

   // Stage B: simple ops, magnitudes, multiply
   logic signed [33:0]   sum, dif, incv, decv, simple34;
   logic signed [49:0]   fromint;
   logic [31:0]          ma, mb;
   logic [63:0]          prod_in;
   logic [31:0]          res_b_in;
   logic                 cmp_b_in;
   fpa_pkg::status_type  st_b_in;

   always_comb begin
      sum  = 34'(a_ff) + 34'(b_ff);
      dif  = 34'(a_ff) - 34'(b_ff);
      incv = 34'(a_ff) + 34'sd1;
      decv = 34'(a_ff) - 34'sd1;
      fromint = 50'(a_ff) <<< FRAC_BITS;
      ma = a_ff[31] ? 32'(-a_ff) : 32'(a_ff);
      mb = b_ff[31] ? 32'(-b_ff) : 32'(b_ff);
      prod_in = 64'(ma) * 64'(mb);
      res_b_in = '0;
      cmp_b_in = 1'b0;
      st_b_in  = fpa_pkg::ST_OK;
      simple34 = '0;
      case (mode_a_ff)
         fpa_pkg::MODE_ADD: simple34 = sum;
         fpa_pkg::MODE_SUB: simple34 = dif;
         fpa_pkg::MODE_INC: simple34 = incv;
         fpa_pkg::MODE_DEC: simple34 = decv;
         default:           simple34 = '0;
      endcase
      case (mode_a_ff)
         fpa_pkg::MODE_ADD, fpa_pkg::MODE_SUB, fpa_pkg::MODE_INC,
         fpa_pkg::MODE_DEC: begin
            if (simple34 > WMAX34) begin
               res_b_in = 32'(WMAX34);
               st_b_in  = fpa_pkg::ST_OVF;
            end else if (simple34 < WMIN34) begin
               res_b_in = 32'(WMIN34);
               st_b_in  = fpa_pkg::ST_OVF;
            end else begin
               res_b_in = 32'(simple34);
            end
         end
         fpa_pkg::MODE_FROMINT: begin
            if (fromint > WMAX50) begin
               res_b_in = 32'(WMAX50);
               st_b_in  = fpa_pkg::ST_OVF;
            end else if (fromint < WMIN50) begin
               res_b_in = 32'(WMIN50);
               st_b_in  = fpa_pkg::ST_OVF;
            end else begin
               res_b_in = 32'(fromint);
            end
         end
         fpa_pkg::MODE_GT:    cmp_b_in = a_ff >  b_ff;
         fpa_pkg::MODE_LT:    cmp_b_in = a_ff <  b_ff;
         fpa_pkg::MODE_GE:    cmp_b_in = a_ff >= b_ff;
         fpa_pkg::MODE_LE:    cmp_b_in = a_ff <= b_ff;
         fpa_pkg::MODE_EQ:    cmp_b_in = a_ff == b_ff;
         fpa_pkg::MODE_NE:    cmp_b_in = a_ff != b_ff;
         fpa_pkg::MODE_MIN:   res_b_in = (a_ff < b_ff) ? a_ff : b_ff;
         fpa_pkg::MODE_MAX:   res_b_in = (a_ff > b_ff) ? a_ff : b_ff;
         fpa_pkg::MODE_TOINT: res_b_in = 32'(a_ff >>> FRAC_BITS);
         fpa_pkg::MODE_DIV: begin
            // divide by zero saturates by the sign of the dividend
            if (mb == '0) begin
               st_b_in = fpa_pkg::ST_DZ;
               if (a_ff > 0) begin
                  res_b_in = 32'(WMAX34);
               end else if (a_ff < 0) begin
                  res_b_in = 32'(WMIN34);
               end
            end
         end
         default: res_b_in = '0;
      endcase
   end

   logic                 vb_ff;
   fpa_pkg::mode_type    mode_b_ff;
   logic [31:0]          res_b_ff;
   logic                 cmp_b_ff;
   fpa_pkg::status_type  st_b_ff;
   logic                 neg_b_ff;
   logic [63:0]          prod_ff;
   logic [NW-1:0]        num_b_ff;
   logic [DW-1:0]        den_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_b_ff <= mode_a_ff;
         res_b_ff  <= res_b_in;
         cmp_b_ff  <= cmp_b_in;
         st_b_ff   <= st_b_in;
         neg_b_ff  <= a_ff[31] ^ b_ff[31];
         prod_ff   <= prod_in;
         // rounded divide: (2*num + den) / (2*den)
         num_b_ff  <= NW'((64'(ma) << (FRAC_BITS + 1)) + 64'(mb));
         den_b_ff  <= DW'(64'(mb) << 1);
      end
   end

   // Stage C: round and clamp the product
   logic [63:0]        q_mul, lim;
   fpa_pkg::side_type  side_in;

   always_comb begin
      q_mul = (prod_ff + HALF) >> FRAC_BITS;
      lim   = neg_b_ff ? LIM_NEG : LIM_POS;
      side_in.mode   = mode_b_ff;
      side_in.result = res_b_ff;
      side_in.cmp    = cmp_b_ff;
      side_in.status = st_b_ff;
      side_in.neg    = neg_b_ff;
      if (mode_b_ff == fpa_pkg::MODE_MUL) begin
         if (q_mul > lim) begin
            side_in.status = fpa_pkg::ST_OVF;
            side_in.result = neg_b_ff ? 32'(WMIN34) : 32'(WMAX34);
         end else begin
            side_in.result = neg_b_ff ? 32'(-q_mul) : 32'(q_mul);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_side <= side_in;
         out_num  <= num_b_ff;
         out_den  <= den_b_ff;
      end
   end

endmodule

// File: rtl/fpa_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per pipeline stage.
module fpa_divider #(
   parameter int NW = 41,
   parameter int DW = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  fpa_pkg::side_type    in_side,
   input  logic [NW-1:0]        in_num,
   input  logic [DW-1:0]        in_den,
   output logic                 out_valid,
   output fpa_pkg::side_type    out_side,
   output logic [NW-1:0]        out_quot
);

   logic                v_ff    [NW];
   fpa_pkg::side_type   side_ff [NW];
   logic [NW-1:0]       num_ff  [NW];
   logic [DW-1:0]       den_ff  [NW];
   logic [DW-1:0]       rem_ff  [NW];
   logic [NW-1:0]       quot_ff [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic               v_src;
      fpa_pkg::side_type  side_src;
      logic [NW-1:0]      num_src, quot_src;
      logic [DW-1:0]      den_src, rem_src;
      logic [DW:0]        trial;
      logic               ge;

      if (i == 0) begin : g_first
         assign v_src    = in_valid;
         assign side_src = in_side;
         assign num_src  = in_num;
         assign den_src  = in_den;
         assign rem_src  = '0;
         assign quot_src = '0;
      end else begin : g_next
         assign v_src    = v_ff[i-1];
         assign side_src = side_ff[i-1];
         assign num_src  = num_ff[i-1];
         assign den_src  = den_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign quot_src = quot_ff[i-1];
      end

      // shift in the next dividend bit and try a subtract
      assign trial = {rem_src, num_src[NW-1]};
      assign ge    = trial >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i] <= side_src;
            num_ff[i]  <= num_src << 1;
            den_ff[i]  <= den_src;
            rem_ff[i]  <= ge ? DW'(trial - {1'b0, den_src}) : DW'(trial);
            quot_ff[i] <= {quot_src[NW-2:0], ge};
         end
      end
   end

   assign out_valid = v_ff[NW-1];
   assign out_side  = side_ff[NW-1];
   assign out_quot  = quot_ff[NW-1];

endmodule
